### rtl/rc4_pkg.sv
// Shared constants, codes and interface types for the RC4 engine.
package rc4_pkg;

    localparam int KEY_MAX_LEN = 256;
    localparam int SBOX_DEPTH  = 256;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = $clog2(SBOX_DEPTH);
    localparam int KCNT_W      = $clog2(KEY_MAX_LEN) + 1;
    localparam int STATUS_W    = 2;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic [STATUS_W-1:0] ST_KEY_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA_OK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_KEY   = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic               key_wr;
        t_addr              key_addr;
        t_byte              key_data;
        logic               start_ksa;
        logic [KCNT_W-1:0]  key_len;
        logic               start_prga;
    } t_eng_req;

    typedef struct packed {
        logic  done;
        t_byte ks_byte;
    } t_eng_rsp;

endpackage

### rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rc4_engine.sv
// S-box sequencer: key schedule and keystream generation around one shared byte adder.
module rc4_engine import rc4_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_eng_req i_req,
    output t_eng_rsp o_rsp
);

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_FILL = 4'd1;
    localparam logic [3:0] K_RD   = 4'd2;
    localparam logic [3:0] K_J    = 4'd3;
    localparam logic [3:0] K_WN   = 4'd4;
    localparam logic [3:0] K_WJ   = 4'd5;
    localparam logic [3:0] P_RJ   = 4'd6;
    localparam logic [3:0] P_WI   = 4'd7;
    localparam logic [3:0] P_OUT  = 4'd8;

    logic [3:0]        r_state, n_state;
    t_addr             r_n, n_n;
    t_addr             r_k, n_k;
    t_addr             r_i, n_i;
    t_addr             r_j, n_j;
    t_addr             r_t, n_t;
    t_byte             r_sa, n_sa;
    t_byte             r_sb, n_sb;
    logic [KCNT_W-1:0] r_len, n_len;

    logic  s_we;
    t_addr s_waddr;
    t_byte s_wdata;
    t_addr s_raddr;
    t_byte s_rdata;
    t_byte k_rdata;

    // shared adder
    t_byte add_a, add_b, add_c, add_sum;
    assign add_sum = add_a + add_b + add_c;

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX_LEN)) u_key (
        .i_clk   (i_clk),
        .i_we    (i_req.key_wr),
        .i_waddr (i_req.key_addr[$clog2(KEY_MAX_LEN)-1:0]),
        .i_wdata (i_req.key_data),
        .i_raddr (r_k[$clog2(KEY_MAX_LEN)-1:0]),
        .o_rdata (k_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_len   = r_len;
        s_we    = 1'b0;
        s_waddr = r_n;
        s_wdata = r_n;
        s_raddr = r_n;
        add_a   = r_j;
        add_b   = s_rdata;
        add_c   = '0;
        o_rsp   = '0;
        unique case (r_state)
            E_IDLE: begin
                if (i_req.start_ksa) begin
                    n_n     = '0;
                    n_len   = i_req.key_len;
                    n_state = E_FILL;
                end else if (i_req.start_prga) begin
                    n_i     = r_i + 1'b1;
                    s_raddr = r_i + 1'b1;
                    n_state = P_RJ;
                end
            end
            E_FILL: begin
                s_we = 1'b1;
                n_n  = r_n + 1'b1;
                if (r_n == '1) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = K_RD;
                end
            end
            K_RD: begin
                n_state = K_J;
            end
            K_J: begin
                add_c   = k_rdata;
                n_j     = add_sum;
                n_sa    = s_rdata;
                s_raddr = add_sum;
                n_state = K_WN;
            end
            K_WN: begin
                s_we    = 1'b1;
                s_wdata = s_rdata;
                n_state = K_WJ;
            end
            K_WJ: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_sa;
                n_n     = r_n + 1'b1;
                // key index runs modulo the key length
                if ({1'b0, r_k} + 1'b1 == r_len) begin
                    n_k = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
                if (r_n == '1) begin
                    o_rsp.done = 1'b1;
                    n_i        = '0;
                    n_j        = '0;
                    n_state    = E_IDLE;
                end else begin
                    n_state = K_RD;
                end
            end
            P_RJ: begin
                n_j     = add_sum;
                n_sa    = s_rdata;
                s_raddr = add_sum;
                n_state = P_WI;
            end
            P_WI: begin
                // S[i] <= S[j]; read S[t] in parallel, collisions fixed up next cycle
                s_we    = 1'b1;
                s_waddr = r_i;
                s_wdata = s_rdata;
                n_sb    = s_rdata;
                add_a   = r_sa;
                n_t     = add_sum;
                s_raddr = add_sum;
                n_state = P_OUT;
            end
            P_OUT: begin
                s_we       = 1'b1;
                s_waddr    = r_j;
                s_wdata    = r_sa;
                o_rsp.done = 1'b1;
                if (r_t == r_j) begin
                    o_rsp.ks_byte = r_sa;
                end else if (r_t == r_i) begin
                    o_rsp.ks_byte = r_sb;
                end else begin
                    o_rsp.ks_byte = s_rdata;
                end
                n_state = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_k   <= n_k;
        r_t   <= n_t;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_len <= n_len;
    end

endmodule

### rtl/rc4_stream_cipher_top.sv
// RC4 stream cipher top level: stream handshakes, key loading and result buffering.
//
// RC4 engine on stream ports. A key byte (tuser 0) is stored in the key RAM; the
// word with tlast set ends the key and starts the key schedule, which keeps the
// engine busy while it fills the S-box and then, for each entry, reads S[n] and
// the key byte, adds up j, reads S[j] and writes the swap in two steps, set by
// the single write and single read port of the S-box RAM. It answers with status
// 0. A data byte (tuser 1) keeps the engine busy through an S[i] read, an S[j]
// read and two swap writes with the S[t] read folded in, and returns the byte
// XORed with the next keystream byte, status 1. Data before a complete key is
// rejected at once with status 2. Key bytes beyond 256 are dropped. Every result
// passes a holding register on its way to the output register, so the next word
// is taken only once the result has left the holding register. One result may
// wait on the master side while the next word is processed.
module rc4_stream_cipher_top import rc4_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] byte_in
    input  logic                s_axis_tlast,   // is_last
    input  logic                s_axis_tuser,   // [0] op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] byte_out
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    logic              r_loading, r_keyed, r_busy, r_busy_op;
    logic [KCNT_W-1:0] r_key_count;
    t_byte             r_data;
    logic              r_pend_valid;
    logic [STATUS_W-1:0] r_pend_status;
    t_byte             r_pend_byte;
    logic              r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_byte             r_out_byte;

    logic              in_acc, key_acc, data_acc, storable;
    logic [KCNT_W-1:0] base_count, new_count;
    logic              pend_move;
    t_eng_req          req;
    t_eng_rsp          rsp;

    assign s_axis_tready = !r_busy && !r_pend_valid;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign key_acc  = in_acc && (s_axis_tuser == OP_KEY);
    assign data_acc = in_acc && (s_axis_tuser == OP_DATA);

    // first byte of a new key restarts the count
    assign base_count = r_loading ? r_key_count : '0;
    assign storable   = base_count < KCNT_W'(KEY_MAX_LEN);
    assign new_count  = base_count + KCNT_W'(storable);

    always_comb begin
        req            = '0;
        req.key_wr     = key_acc && storable;
        req.key_addr   = base_count[ADDR_W-1:0];
        req.key_data   = s_axis_tdata;
        req.start_ksa  = key_acc && s_axis_tlast;
        req.key_len    = new_count;
        req.start_prga = data_acc && r_keyed;
    end

    rc4_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign pend_move = r_pend_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading    <= 1'b0;
            r_keyed      <= 1'b0;
            r_busy       <= 1'b0;
            r_key_count  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (key_acc) begin
                r_keyed <= 1'b0;
                if (s_axis_tlast) begin
                    r_loading   <= 1'b0;
                    r_key_count <= '0;
                    r_busy      <= 1'b1;
                end else begin
                    r_loading   <= 1'b1;
                    r_key_count <= new_count;
                end
            end else if (data_acc && r_keyed) begin
                r_busy <= 1'b1;
            end

            if (r_busy && rsp.done) begin
                r_busy <= 1'b0;
                if (r_busy_op == OP_KEY) begin
                    r_keyed <= 1'b1;
                end
            end

            if ((r_busy && rsp.done) || (data_acc && !r_keyed)) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end

            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_busy_op <= s_axis_tuser;
            r_data    <= s_axis_tdata;
        end
        if (r_busy && rsp.done) begin
            if (r_busy_op == OP_KEY) begin
                r_pend_status <= ST_KEY_DONE;
                r_pend_byte   <= '0;
            end else begin
                r_pend_status <= ST_DATA_OK;
                r_pend_byte   <= r_data ^ rsp.ks_byte;
            end
        end else if (data_acc && !r_keyed) begin
            r_pend_status <= ST_NO_KEY;
            r_pend_byte   <= '0;
        end
        if (pend_move) begin
            r_out_status <= r_pend_status;
            r_out_byte   <= r_pend_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_status;

endmodule
